// ===== hw/rtl/ttn_pkg.sv =====
// ttn_pkg: shared types and constants for the tick to nanosecond converter
// no dependencies

package ttn_pkg;

   localparam int unsigned TICK_W   = 64;
   localparam int unsigned NS_W     = 30;
   localparam int unsigned NUM_MAX_W = TICK_W + NS_W;
   localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

   // one word moving down the divider pipeline
   typedef struct packed {
      logic                  valid;
      logic [NUM_MAX_W-1:0]  num;     // numerator, msb first, left aligned
      logic [TICK_W-1:0]     rem;     // partial remainder, below the rate when the rate is nonzero
      logic [TICK_W-1:0]     quot;    // low quotient bits
      logic                  sticky;  // quotient bit beyond 64 seen
   } div_word_type;

endpackage

// ===== hw/rtl/ttn_if.sv =====
// ttn channel interfaces: request, response and csr write channels
// depends on ttn_pkg

interface ttn_req_if;
   import ttn_pkg::*;
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] ticks;
   modport source (output valid, output ticks, input ready);
   modport sink   (input valid, input ticks, output ready);
endinterface

interface ttn_rsp_if;
   import ttn_pkg::*;
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] nanoseconds;
   logic              saturated;
   modport source (output valid, output nanoseconds, output saturated, input ready);
   modport sink   (input valid, input nanoseconds, input saturated, output ready);
endinterface

interface ttn_csr_if;
   import ttn_pkg::*;
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ttn_mul.sv =====
// ttn_mul: two-stage scaling of the tick count by one billion
// depends on ttn_pkg

module ttn_mul
   import ttn_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [TICK_W-1:0] in_ticks,
   output div_word_type      out_word
);

   localparam int unsigned NUM_W = COUNTER_WIDTH + NS_W;
   localparam logic [TICK_W:0] MASK_FULL = (65'd1 << COUNTER_WIDTH) - 65'd1;

   logic [TICK_W-1:0]      masked;
   logic                   v1_ff;
   logic [31+NS_W:0]       lo_ff, lo_in;
   logic [31+NS_W:0]       hi_ff, hi_in;
   logic [NUM_MAX_W-1:0]   prod;
   div_word_type           word_ff, word_in;

   assign masked = in_ticks & MASK_FULL[TICK_W-1:0];
   assign lo_in  = {{NS_W{1'b0}}, masked[31:0]}  * {32'd0, NS_PER_SEC};
   assign hi_in  = {{NS_W{1'b0}}, masked[63:32]} * {32'd0, NS_PER_SEC};

   // product of a masked count fits in NUM_W bits; left align it
   assign prod = {hi_ff, 32'd0} + {32'd0, lo_ff};

   always_comb begin
      word_in        = '0;
      word_in.valid  = v1_ff;
      word_in.num    = prod << (NUM_MAX_W - NUM_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         v1_ff         <= in_valid;
         word_ff.valid <= word_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff          <= lo_in;
         hi_ff          <= hi_in;
         word_ff.num    <= word_in.num;
         word_ff.rem    <= word_in.rem;
         word_ff.quot   <= word_in.quot;
         word_ff.sticky <= word_in.sticky;
      end
   end

   assign out_word = word_ff;

endmodule

// ===== hw/rtl/ttn_div_stage.sv =====
// ttn_div_stage: one restoring division step, one quotient bit per stage
// depends on ttn_pkg

module ttn_div_stage
   import ttn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [TICK_W-1:0] rate,
   input  div_word_type      in_word,
   output div_word_type      out_word
);

   logic [TICK_W:0] shifted;
   logic            fits;
   logic [TICK_W:0] diff;
   div_word_type    word_ff, word_in;

   assign shifted = {in_word.rem, in_word.num[NUM_MAX_W-1]};
   assign fits    = shifted >= {1'b0, rate};
   assign diff    = shifted - {1'b0, rate};

   always_comb begin
      word_in        = in_word;
      word_in.num    = {in_word.num[NUM_MAX_W-2:0], 1'b0};
      word_in.rem    = fits ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
      word_in.quot   = {in_word.quot[TICK_W-2:0], fits};
      word_in.sticky = in_word.sticky | in_word.quot[TICK_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff.valid <= word_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff.num    <= word_in.num;
         word_ff.rem    <= word_in.rem;
         word_ff.quot   <= word_in.quot;
         word_ff.sticky <= word_in.sticky;
      end
   end

   assign out_word = word_ff;

endmodule

// ===== hw/rtl/tick_to_nanosecond_converter.sv =====
// tick_to_nanosecond_converter: top level, counter ticks to saturated nanoseconds
// depends on ttn_pkg, ttn_if, ttn_mul and ttn_div_stage
//
// usage
//   req_chan carries one tick count per word, rsp_chan returns one word per
//   request with the value in nanoseconds and a saturated flag, csr_chan
//   writes the tick rate (ticks per second), always ready, reset value 1
//   result is floor(ticks * 1e9 / rate) clamped to all ones; rate zero gives 0
//   pipeline: two multiply stages, one divider stage per numerator bit, one
//   output register; throughput: one word per cycle unless rsp_chan stalls,
//   set by the fully pipelined divider
//   the rate is read live by every divider stage, so write it only while idle
//   reset empties the pipeline and sets the rate to 1
//   a stall on rsp_chan freezes the whole pipeline in place; req ready drops
//   in the same cycle, nothing is lost or repeated

module tick_to_nanosecond_converter
   import ttn_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   ttn_req_if.sink    req_chan,
   ttn_rsp_if.source  rsp_chan,
   ttn_csr_if.sink    csr_chan
);

   localparam int unsigned NUM_W = COUNTER_WIDTH + NS_W;

   logic              enable;
   logic [TICK_W-1:0] rate_ff;
   div_word_type      chain [NUM_W+1];

   // output register
   logic              rsp_valid_ff;
   logic [TICK_W-1:0] rsp_ns_ff, rsp_ns_in;
   logic              rsp_sat_ff, rsp_sat_in;
   logic              rate_zero;

   // whole pipeline moves unless a finished word is waiting
   assign enable = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = enable;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 64'd1;
      end else if (csr_chan.valid) begin
         rate_ff <= csr_chan.data;
      end
   end

   ttn_mul #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_mul (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_chan.valid),
      .in_ticks (req_chan.ticks),
      .out_word (chain[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      ttn_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .rate     (rate_ff),
         .in_word  (chain[i]),
         .out_word (chain[i+1])
      );
   end

   // any quotient bit above 64 means the quotient overflowed
   assign rate_zero  = rate_ff == '0;
   assign rsp_sat_in = !rate_zero && chain[NUM_W].sticky;
   assign rsp_ns_in  = rate_zero  ? '0 :
                       rsp_sat_in ? '1 : chain[NUM_W].quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= chain[NUM_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ns_ff  <= rsp_ns_in;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.nanoseconds = rsp_ns_ff;
   assign rsp_chan.saturated   = rsp_sat_ff;

   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> rsp_ns_ff == '1)
      else $error("saturated word not all ones");

   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rate_zero && $stable(rate_ff) |-> rsp_ns_ff == '0 && !rsp_sat_ff)
      else $error("zero rate gave non-zero word");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(chain[NUM_W].valid))
      else $error("response without pipeline word");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(chain[NUM_W].valid) && $stable(chain[0].valid))
      else $error("pipeline moved during stall");

endmodule

// ===== sim/ttn_checker.sv =====
// ttn_checker: watches the request, response and csr channels of the converter
// predicts nanoseconds and saturation per request word and compares responses
// depends on ttn_pkg and ttn_if

module ttn_checker
   import ttn_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   ttn_req_if.sink   req_mon,
   ttn_rsp_if.sink   rsp_mon,
   ttn_csr_if.sink   csr_mon,
   output int        fail_count,
   output int        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TICK_W-1:0] nanoseconds;
      logic              saturated;
   } ns_result_type;

   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] NS_SEC   = 64'd1000000000;

   logic [63:0]   rate_shadow;
   ns_result_type expected_ns_q[$];

   // reduced-remainder add: acc + add mod m, returns carry
   function automatic bit mod_add(inout logic [63:0] acc, input logic [63:0] add,
                                  input logic [63:0] m);
      logic [63:0] gap;
      gap = m - add;
      if (acc >= gap) begin
         acc = acc - gap;
         return 1'b1;
      end
      acc = acc + add;
      return 1'b0;
   endfunction

   function automatic logic [63:0] frac_ns(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] r_copy;
      q = 0;
      r = 0;
      for (int b = 29; b >= 0; b--) begin
         r_copy = r;
         q = q * 2 + mod_add(r, r_copy, den);
         if (NS_SEC[b]) q = q + mod_add(r, num, den);
      end
      return q;
   endfunction

   function automatic ns_result_type convert_ticks(logic [63:0] raw, logic [63:0] rate);
      ns_result_type res;
      logic [63:0]   t;
      logic [63:0]   secs;
      logic [63:0]   whole;
      logic [63:0]   fr;
      t = (COUNTER_WIDTH >= 64) ? raw : (raw & ((64'd1 << COUNTER_WIDTH) - 1));
      res = '0;
      if (rate != 0) begin
         secs = t / rate;
         if (secs > ALL_ONES / NS_SEC) begin
            res.nanoseconds = ALL_ONES;
            res.saturated   = 1'b1;
         end else begin
            whole = secs * NS_SEC;
            fr    = frac_ns(t % rate, rate);
            if (fr > ALL_ONES - whole) begin
               res.nanoseconds = ALL_ONES;
               res.saturated   = 1'b1;
            end else begin
               res.nanoseconds = whole + fr;
            end
         end
      end
      return res;
   endfunction

   assign pending_count = expected_ns_q.size();

   always @(posedge clock) begin
      ns_result_type exp_r;
      if (reset) begin
         rate_shadow = 64'd1;
         expected_ns_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) rate_shadow = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            expected_ns_q.push_back(convert_ticks(req_mon.ticks, rate_shadow));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ns_q.size() == 0) begin
               $error("unexpected response word ns=%0h", rsp_mon.nanoseconds);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_ns_q.pop_front();
               if (exp_r.nanoseconds !== rsp_mon.nanoseconds) begin
                  $error("nanoseconds expected %0h actual %0h",
                         exp_r.nanoseconds, rsp_mon.nanoseconds);
                  fail_count <= fail_count + 1;
               end else if (exp_r.saturated !== rsp_mon.saturated) begin
                  $error("saturated expected %0b actual %0b",
                         exp_r.saturated, rsp_mon.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/tb_tick_to_nanosecond_converter.sv =====
// tb_tick_to_nanosecond_converter: stimulus and verdict for the converter
// depends on ttn_pkg, ttn_if, the converter rtl and ttn_checker

module tb_tick_to_nanosecond_converter;
   import ttn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CW      = 64;
   localparam int          LATENCY = CW + 33;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   bit   stim_done = 1'b0;
   logic [63:0] rate_now = 64'd1;

   ttn_req_if req_chan();
   ttn_rsp_if rsp_chan();
   ttn_csr_if csr_chan();

   always #4 clock = ~clock;

   tick_to_nanosecond_converter #(.COUNTER_WIDTH(CW)) dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   ttn_checker #(.COUNTER_WIDTH(CW)) u_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink), .csr_mon(csr_chan.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // ticks shaped to hit the interesting regions for the current rate
   function automatic logic [63:0] pick_ticks();
      int          p;
      logic [63:0] secs;
      p = $urandom_range(0, 9);
      case (p)
         0: return rand64();
         1: return rand64() >> $urandom_range(0, 63);
         2: return (rand64() % ((rate_now == 0) ? 64'd1 : rate_now));
         3: return ~64'd0 - $urandom_range(0, 3);
         default: begin
            // whole seconds near the saturation boundary, or small counts
            secs = ($urandom_range(0, 1)) ? (64'd18446744073 - $urandom_range(0, 2))
                                          : $urandom_range(0, 1000);
            return secs * rate_now + (rand64() % ((rate_now == 0) ? 64'd1 : rate_now));
         end
      endcase
   endfunction

   // response stall, idle a random while then ready for a while
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_chan.ready <= 1'b0;
         repeat (gap_len()) @(negedge clock);
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // one request word, held until accepted
   task automatic send_ticks(logic [63:0] t);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ticks <= t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // csr write only once the pipeline has drained
   task automatic write_rate(logic [63:0] r);
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= r;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      rate_now = r;
   endtask

   initial begin
      logic [63:0] rates[8];
      req_chan.valid = 1'b0;
      req_chan.ticks = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed: reset rate of 1 and other written rates, extremes and saturation boundary
      send_ticks(64'd0);
      send_ticks(~64'd0);
      send_ticks(64'd18446744073);
      send_ticks(64'd18446744074);
      write_rate(64'd0);
      send_ticks(~64'd0);
      send_ticks(64'd12345);
      write_rate(~64'd0);
      send_ticks(~64'd0);
      send_ticks(~64'd1);
      send_ticks(64'd1);
      write_rate(64'd3);
      send_ticks(64'd2);
      send_ticks(64'd55340232221);
      write_rate(64'd1000);
      // sum overflow: top whole seconds plus a large fraction
      send_ticks(64'd18446744073 * 64'd1000 + 64'd999);
      send_ticks(64'd18446744073 * 64'd1000 + 64'd708);
      send_ticks(64'd18446744073 * 64'd1000 + 64'd709);
      send_ticks(64'd18446744073 * 64'd1000 + 64'd710);
      write_rate(64'd1000000000);
      send_ticks(~64'd0);
      send_ticks(64'hAAAA_AAAA_AAAA_AAAA);
      send_ticks(64'h5555_5555_5555_5555);

      // random phases over several rates
      rates = '{64'd1, 64'd0, ~64'd0, 64'd32768, 64'd19200000, 64'd0, 64'd0, 64'd0};
      for (int ph = 0; ph < 11; ph++) begin
         if (ph < 5) write_rate(rates[ph]);
         else if (ph % 2) write_rate(rand64());
         else write_rate(64'd1 << $urandom_range(0, 63) | $urandom_range(0, 7));
         for (int i = 0; i < 100; i++) send_ticks(pick_ticks());
      end
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      stim_done = 1'b1;
   end

   // verdict
   initial begin
      wait (stim_done);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   // watchdog well beyond the slowest correct run
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/ttn_pkg.sv
hw/rtl/ttn_if.sv
hw/rtl/ttn_mul.sv
hw/rtl/ttn_div_stage.sv
hw/rtl/tick_to_nanosecond_converter.sv
sim/ttn_checker.sv
sim/tb_tick_to_nanosecond_converter.sv
